// ===== src/pn3d_pkg.sv =====
// Shared constants, types and arithmetic helpers for the 3D gradient noise core.
package pn3d_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int FRAC_SHR = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
   localparam int FRAC_SHL = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
   localparam logic [31:0] FRAC_MASK = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);

   localparam logic [31:0] PRIME_X   = 32'd73856093;
   localparam logic [31:0] PRIME_Y   = 32'd19349663;
   localparam logic [31:0] PRIME_Z   = 32'd83492791;
   localparam logic [31:0] HASH_XOR  = 32'd61;
   localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;
   localparam logic signed [21:0] SMOOTH_15 = 22'sd983040;
   localparam logic signed [21:0] SMOOTH_10 = 22'sd655360;
   localparam logic signed [20:0] ONE_Q16   = 21'sd65536;
   localparam logic signed [20:0] OUT_MIN   = -21'sd262144;
   localparam logic signed [20:0] OUT_MAX   = 21'sd262143;

   typedef logic signed [20:0] val_type;
   typedef logic signed [17:0] wgt_type;

   // fraction of a coordinate brought to 16 bits (floor when narrowing)
   function automatic logic [15:0] frac_q16(input logic [31:0] c);
      logic [47:0] f;
      f = {16'd0, c & FRAC_MASK};
      f = (f >> FRAC_SHR) << FRAC_SHL;
      return f[15:0];
   endfunction

   // seeded first half of the integer mix: xor, xor-shift, multiply
   function automatic logic [31:0] mix_mul(input logic [31:0] v, input logic [31:0] seed);
      logic [31:0] h;
      h = v ^ seed;
      h = (h ^ HASH_XOR) ^ (h >> 16);
      return h * HASH_MUL;
   endfunction

   // low 4 bits of the final xor-shift select the edge gradient
   function automatic val_type grad_dot(input logic [31:0] m, input val_type dx,
                                        input val_type dy, input val_type dz);
      logic [3:0] h;
      val_type gu;
      val_type gv;
      h  = m[3:0] ^ m[18:15];
      gu = (h < 4'd8) ? dx : dy;
      if (h < 4'd4)
         gv = dy;
      else if (h == 4'd12 || h == 4'd14)
         gv = dx;
      else
         gv = dz;
      if (h[0]) gu = -gu;
      if (h[1]) gv = -gv;
      return gu + gv;
   endfunction

   // a + floor(w * (b - a) / 2^16)
   function automatic val_type blend(input val_type a, input val_type b, input wgt_type w);
      logic signed [21:0] d;
      logic signed [39:0] p;
      d = 22'(b) - 22'(a);
      p = 40'(w) * 40'(d);
      return a + val_type'(p >>> 16);
   endfunction

endpackage

// ===== src/perlin_noise_3d_core.sv =====
// Top level of the pipelined 3D gradient noise core.
//
// Usage: one point enters on the req_ channel as three signed coordinates
// (COORD_FRAC_BITS fraction bits). One noise item (signed Q2.16) leaves on
// the rsp_ channel per point, in order. An item is taken when valid is high
// and stall low; the core raises req_stall itself when it cannot take one.
// The csr_ channel loads the seed; csr_ready is always high. Write it only
// while the core holds no items.
// Flow: an accepted item passes the six register stages (lattice
// multiplies, hash multiply and smoothing polynomial, gradient select,
// then one blend multiply per axis) in order, and rsp_valid rises once it
// reaches the last. Throughput: one item per cycle while rsp_stall is low;
// each stage holds one item.
// Stall: each stage moves on when the next is empty or moving, so bubbles
// close up; with rsp_stall high and every stage full, req_stall goes high.
// The rsp_ item and its valid hold while stalled.
// Reset (synchronous, active high): all stages empty, seed cleared to 0.
module perlin_noise_3d_core
   import pn3d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [18:0] rsp_noise_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_noise_seed
);

   logic [31:0] seed_ff;

   // stage valid bits and load enables
   logic [6:1] vld_ff;
   logic [6:1] en;

   // stage 1: lattice products, fractions, t^2
   logic [31:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [15:0] s1_f_ff  [3];
   logic [15:0] s1_t2_ff [3];
   // stage 2: mixed hashes, t^3 and the inner polynomial
   logic [31:0] s2_m_ff  [8];
   logic [15:0] s2_f_ff  [3];
   logic [15:0] s2_t3_ff [3];
   logic signed [21:0] s2_a_ff [3];
   // stage 3: corner dots, weights
   val_type     s3_n_ff [8];
   wgt_type     s3_w_ff [3];
   // stage 4..6: blends along x, y, z
   val_type     s4_b_ff [4];
   wgt_type     s4_w_ff [2];
   val_type     s5_b_ff [2];
   wgt_type     s5_w_ff;
   logic signed [18:0] s6_r_ff;

   always_comb begin
      en[6] = !vld_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall       = !en[1];
   assign rsp_valid       = vld_ff[6];
   assign rsp_noise_value = s6_r_ff;
   assign csr_ready       = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         seed_ff <= '0;
      end else begin
         if (csr_valid) seed_ff <= csr_noise_seed;
         if (en[1]) vld_ff[1] <= req_valid;
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1 inputs
   logic [31:0] cell_x, cell_y, cell_z;
   logic [15:0] f1_in [3];
   always_comb begin
      cell_x   = 32'(req_coord_x >>> COORD_FRAC_BITS);
      cell_y   = 32'(req_coord_y >>> COORD_FRAC_BITS);
      cell_z   = 32'(req_coord_z >>> COORD_FRAC_BITS);
      f1_in[0] = frac_q16(req_coord_x);
      f1_in[1] = frac_q16(req_coord_y);
      f1_in[2] = frac_q16(req_coord_z);
   end

   // stage 2 inputs: corner hash before the mixing multiply
   logic [31:0] corner_v [8];
   always_comb begin
      for (int c = 0; c < 8; c++) begin
         corner_v[c] = (c[0] ? s1_px_ff + PRIME_X : s1_px_ff)
                     ^ (c[1] ? s1_py_ff + PRIME_Y : s1_py_ff)
                     ^ (c[2] ? s1_pz_ff + PRIME_Z : s1_pz_ff);
      end
   end

   // stage 3 inputs: offsets to the near and far corners
   val_type d0 [3];
   val_type d1 [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d0[a] = val_type'({1'b0, s2_f_ff[a]});
         d1[a] = d0[a] - ONE_Q16;
      end
   end

   logic signed [20:0] r_full;
   assign r_full = blend(s5_b_ff[0], s5_b_ff[1], s5_w_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_px_ff <= cell_x * PRIME_X;
         s1_py_ff <= cell_y * PRIME_Y;
         s1_pz_ff <= cell_z * PRIME_Z;
         for (int a = 0; a < 3; a++) begin
            s1_f_ff[a]  <= f1_in[a];
            s1_t2_ff[a] <= 16'((32'(f1_in[a]) * 32'(f1_in[a])) >> 16);
         end
      end
      if (en[2]) begin
         for (int c = 0; c < 8; c++) begin
            s2_m_ff[c] <= mix_mul(corner_v[c], seed_ff);
         end
         for (int a = 0; a < 3; a++) begin
            s2_f_ff[a]  <= s1_f_ff[a];
            s2_t3_ff[a] <= 16'((32'(s1_t2_ff[a]) * 32'(s1_f_ff[a])) >> 16);
            // floor(t * (6t - 15)) + 10
            s2_a_ff[a]  <= 22'((40'($signed({1'b0, s1_f_ff[a]}))
                           * 40'(22'($signed({1'b0, s1_f_ff[a]})) * 22'sd6 - SMOOTH_15))
                           >>> 16) + SMOOTH_10;
         end
      end
      if (en[3]) begin
         for (int c = 0; c < 8; c++) begin
            s3_n_ff[c] <= grad_dot(s2_m_ff[c], c[0] ? d1[0] : d0[0],
                                   c[1] ? d1[1] : d0[1], c[2] ? d1[2] : d0[2]);
         end
         for (int a = 0; a < 3; a++) begin
            s3_w_ff[a] <= wgt_type'((40'($signed({1'b0, s2_t3_ff[a]})) * 40'(s2_a_ff[a]))
                          >>> 16);
         end
      end
      if (en[4]) begin
         for (int j = 0; j < 4; j++) begin
            s4_b_ff[j] <= blend(s3_n_ff[2*j], s3_n_ff[2*j+1], s3_w_ff[0]);
         end
         s4_w_ff[0] <= s3_w_ff[1];
         s4_w_ff[1] <= s3_w_ff[2];
      end
      if (en[5]) begin
         s5_b_ff[0] <= blend(s4_b_ff[0], s4_b_ff[1], s4_w_ff[0]);
         s5_b_ff[1] <= blend(s4_b_ff[2], s4_b_ff[3], s4_w_ff[0]);
         s5_w_ff    <= s4_w_ff[1];
      end
      if (en[6]) begin
         if (r_full < OUT_MIN)      s6_r_ff <= 19'(OUT_MIN);
         else if (r_full > OUT_MAX) s6_r_ff <= 19'(OUT_MAX);
         else                       s6_r_ff <= 19'(r_full);
      end
   end

   // with the output free, nothing holds back the input
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("input stalled while output free");
   // input back-pressure only when the first stage is occupied
   assert property (@(posedge clock) disable iff (reset) req_stall |-> vld_ff[1])
      else $error("input stalled with empty first stage");
   // reset empties the pipeline
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

endmodule

// ===== test/perlin_noise_3d_core_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3D gradient noise core: noise prediction and in-order comparison.
module perlin_noise_3d_core_checker
   import pn3d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [18:0] rsp_noise_value,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [31:0]        csr_noise_seed,
   output int                 fail_count,
   output int                 pending_count
);

   logic [31:0]        seed_reg;
   logic signed [18:0] noise_queue[$];

   function automatic longint floor16(input longint v);
      return v >>> 16;
   endfunction

   function automatic logic [31:0] corner_hash(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
      logic [31:0] h;
      h = ((x * 32'd73856093) ^ (y * 32'd19349663) ^ (z * 32'd83492791)) ^ seed_reg;
      h = (h ^ 32'd61) ^ (h >> 16);
      h = h * 32'h27d4eb2d;
      h = h ^ (h >> 15);
      return h & 32'h7fffffff;
   endfunction

   function automatic longint edge_dot(input logic [31:0] hash, input longint dx,
                                       input longint dy, input longint dz);
      logic [3:0] h;
      longint gu, gv;
      h  = hash[3:0];
      gu = (h < 8) ? dx : dy;
      gv = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
      if (h[0]) gu = -gu;
      if (h[1]) gv = -gv;
      return gu + gv;
   endfunction

   function automatic longint fade(input longint t);
      longint t2, t3, a;
      t2 = floor16(t * t);
      t3 = floor16(t2 * t);
      a  = floor16(t * (t * 6 - 15 * 65536)) + 10 * 65536;
      return floor16(t3 * a);
   endfunction

   function automatic longint lerp16(input longint a, input longint b, input longint w);
      return a + floor16(w * (b - a));
   endfunction

   function automatic logic signed [18:0] point_noise(input logic signed [31:0] cx,
                                                      input logic signed [31:0] cy,
                                                      input logic signed [31:0] cz);
      logic [31:0] xi, yi, zi;
      longint xf, yf, zf, x1, y1, z1, u, v, w, r;
      longint n[8];
      xi = 32'(longint'(cx) >>> COORD_FRAC_BITS);
      yi = 32'(longint'(cy) >>> COORD_FRAC_BITS);
      zi = 32'(longint'(cz) >>> COORD_FRAC_BITS);
      xf = longint'(frac_q16(cx));
      yf = longint'(frac_q16(cy));
      zf = longint'(frac_q16(cz));
      x1 = xf - 65536; y1 = yf - 65536; z1 = zf - 65536;
      u = fade(xf); v = fade(yf); w = fade(zf);
      for (int k = 0; k < 8; k++) begin
         n[k] = edge_dot(corner_hash(xi + k[0], yi + k[1], zi + k[2]),
                         k[0] ? x1 : xf, k[1] ? y1 : yf, k[2] ? z1 : zf);
      end
      r = lerp16(lerp16(lerp16(n[0], n[1], u), lerp16(n[2], n[3], u), v),
                 lerp16(lerp16(n[4], n[5], u), lerp16(n[6], n[7], u), v), w);
      if (r < -262144) r = -262144;
      if (r > 262143) r = 262143;
      return 19'(r);
   endfunction

   assign pending_count = noise_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         seed_reg <= '0;
         fail_count <= 0;
         noise_queue.delete();
      end else begin
         if (csr_valid && csr_ready) seed_reg <= csr_noise_seed;
         if (req_valid && !req_stall)
            noise_queue.push_back(point_noise(req_coord_x, req_coord_y, req_coord_z));
         if (rsp_valid && !rsp_stall) begin
            if (noise_queue.size() == 0) begin
               $error("noise_value: unexpected item, actual %0d", rsp_noise_value);
               fail_count <= fail_count + 1;
            end else if (noise_queue[0] !== rsp_noise_value) begin
               $error("noise_value: expected %0d, actual %0d", noise_queue[0], rsp_noise_value);
               fail_count <= fail_count + 1;
               void'(noise_queue.pop_front());
            end else begin
               void'(noise_queue.pop_front());
            end
         end
      end
   end
endmodule

// ===== test/perlin_noise_3d_core_test.sv =====
`timescale 1ns / 1ps
// Top of the noise core testbench: stimulus, seed phases and verdict.
module perlin_noise_3d_core_test;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [18:0] rsp_noise_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [31:0]        csr_noise_seed = '0;
   int                 fail_count, pending_count;
   int                 idle_cycles = 0;
   bit                 calm = 1'b0;    // last part of the run: no idling
   bit                 timed_out = 1'b0;

   localparam int WATCHDOG_LIMIT = 2000;

   always #4 clock = ~clock;

   perlin_noise_3d_core dut (.*);

   perlin_noise_3d_core_checker checker_i (.*);

   // Receiver: random stall bursts mixed with quiet spells; no stalls once calm.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Watchdog: cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("perlin_noise_3d_core test failed");
         $finish;
      end
   end

   // One point, held until taken; an idle burst may come first.
   task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Seed write only with the pipe drained.
   task automatic load_seed(input logic [31:0] s);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_noise_seed <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random coordinate: mostly small lattice values, sometimes any 32 bits.
   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
   endfunction

   initial begin
      logic [31:0] corner_set[8];
      logic [31:0] seeds[5];
      corner_set = '{32'h0000_0000, 32'h0000_ffff, 32'h0001_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'hffff_ffff, 32'hffff_0000, 32'h0000_8000};
      seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678, 32'h8000_0001, 32'h0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, lattice wrap at the top cell, half cells.
      for (int i = 0; i < 8; i++)
         send_point(corner_set[i], corner_set[(i + 3) % 8], corner_set[(i + 5) % 8]);
      for (int i = 0; i < 8; i++)
         send_point(corner_set[i], corner_set[i], corner_set[i]);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000);
      send_point(32'h0001_8000, 32'hfffe_8000, 32'h0000_4000);

      // Random phases under a range of seeds, extremes included.
      for (int p = 0; p < 5; p++) begin
         if (p > 0) load_seed(p == 4 ? $urandom() : seeds[p]);
         if (p == 4) calm = 1'b1;
         for (int i = 0; i < 166; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("perlin_noise_3d_core test passed");
      else
         $display("perlin_noise_3d_core test failed");
      $finish;
   end
endmodule

// ===== perlin_noise_3d_core.f =====
src/pn3d_pkg.sv
src/perlin_noise_3d_core.sv
test/perlin_noise_3d_core_checker.sv
test/perlin_noise_3d_core_test.sv
